// ----- sv/mrct_pkg.sv -----
// ----------------------------------------------------------------------------
// mrct_pkg
// Shared types and constants for the memory range change tracker: request
// and response payloads, the table entry layout and the outcome codes.
// ----------------------------------------------------------------------------
package mrct_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_IDX_W   = 6;

    // Outcome codes reported with every response.
    localparam logic [2:0] OUT_IGNORED      = 3'd0;
    localparam logic [2:0] OUT_UNCHANGED    = 3'd1;
    localparam logic [2:0] OUT_HASH_UPDATED = 3'd2;
    localparam logic [2:0] OUT_EXTENDED     = 3'd3;
    localparam logic [2:0] OUT_ADDED        = 3'd4;
    localparam logic [2:0] OUT_TABLE_FULL   = 3'd5;

    // One incoming request.
    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] size;
        logic [63:0] hash_low;
        logic [63:0] hash_high;
    } mrct_req_t;

    // One response.
    typedef struct packed {
        logic                 write_load;
        logic [2:0]           outcome;
        logic [OUT_IDX_W-1:0] entry_index;
    } mrct_rsp_t;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic [31:0] start_addr;
        logic [31:0] end_addr;
        logic [63:0] hash_low;
        logic [63:0] hash_high;
    } mrct_entry_t;

endpackage

// ----- sv/memory_range_change_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// memory_range_change_tracker_unit
// Tracks recorded memory ranges and their content hashes in an entry memory
// and decides for each request whether the range contents must be emitted.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+-----------------------------
//  req     | in        | req_valid / req_ready | mrct_req_t (addr, size, hash)
//  rsp     | out       | rsp_valid / rsp_ready | mrct_rsp_t (load, outcome, idx)
//
// A request is walked over the valid entries in insertion order, one entry per
// cycle through the single read port of the entry memory, at most TABLE_DEPTH
// entries per request. The walk runs in ST_SCAN and ends in ST_DONE, which loads
// the response register; an ignored request skips the walk and goes straight to
// ST_DONE. The response register frees the walk from the output side: a new
// request is taken while a response still waits, and the walk only stalls at its
// end if the previous response has not been taken. Reset empties the table at
// once; no clearing pass is needed.
//
module memory_range_change_tracker_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  mrct_pkg::mrct_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output mrct_pkg::mrct_rsp_t rsp
);
    import mrct_pkg::*;

    // Sequencer state codes.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    mrct_req_t          req_reg, req_next;
    logic [31:0]        end_reg, end_next;
    mrct_rsp_t          res_reg, res_next;
    logic               rsp_valid_reg, rsp_valid_next;
    mrct_rsp_t          rsp_reg, rsp_next;

    // Entry memory with one write port and one registered read port.
    mrct_entry_t        mem [TABLE_DEPTH];
    mrct_entry_t        rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    mrct_entry_t        wr_data;

    // Scan decode for the entry that the read port presents.
    logic               entry_live;
    logic               entry_hit;
    logic               more_entries;
    logic               out_free;
    logic [COUNT_W-1:0] idx_ext;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    assign idx_ext      = {{(COUNT_W - IDX_W){1'b0}}, idx_reg};
    assign entry_live   = idx_ext < count_reg;
    assign entry_hit    = entry_live
                          && (req_reg.addr >= rd_data_reg.start_addr)
                          && (req_reg.addr <= rd_data_reg.end_addr);
    assign more_entries = (idx_ext + COUNT_W'(1)) < count_reg;

    // Read address: entry 0 at acceptance, the following entry during a walk.
    assign rd_addr = (state_reg == ST_SCAN) ? IDX_W'(idx_reg + IDX_W'(1)) : '0;

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Sequencer next-state and table update logic.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        req_next       = req_reg;
        end_next       = end_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = rd_data_reg;

        // The response register empties when the consumer takes it.
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    end_next = req.addr + req.size;
                    idx_next = '0;
                    if (req.addr == 32'd0 || req.size == 32'd0)
                    begin
                        res_next   = '{write_load: 1'b0, outcome: OUT_IGNORED,
                                       entry_index: '0};
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                priority if (entry_hit)
                begin
                    // Matching entry: extend, refresh the hash or leave it.
                    res_next.entry_index = OUT_IDX_W'(idx_reg);
                    if (end_reg > rd_data_reg.end_addr)
                    begin
                        wr_en                = 1'b1;
                        wr_data.end_addr     = end_reg;
                        wr_data.hash_low     = req_reg.hash_low;
                        wr_data.hash_high    = req_reg.hash_high;
                        res_next.write_load  = 1'b1;
                        res_next.outcome     = OUT_EXTENDED;
                    end
                    else if (req_reg.hash_low == rd_data_reg.hash_low
                             && req_reg.hash_high == rd_data_reg.hash_high)
                    begin
                        res_next.write_load  = 1'b0;
                        res_next.outcome     = OUT_UNCHANGED;
                    end
                    else
                    begin
                        wr_en                = 1'b1;
                        wr_data.hash_low     = req_reg.hash_low;
                        wr_data.hash_high    = req_reg.hash_high;
                        res_next.write_load  = 1'b1;
                        res_next.outcome     = OUT_HASH_UPDATED;
                    end
                    state_next = ST_DONE;
                end
                else if (more_entries)
                begin
                    idx_next = IDX_W'(idx_reg + IDX_W'(1));
                end
                else if (count_reg == COUNT_W'(TABLE_DEPTH))
                begin
                    res_next   = '{write_load: 1'b1, outcome: OUT_TABLE_FULL,
                                   entry_index: '0};
                    state_next = ST_DONE;
                end
                else
                begin
                    // No match: append a new entry at the fill position.
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[IDX_W-1:0];
                    wr_data    = '{start_addr: req_reg.addr, end_addr: end_reg,
                                   hash_low: req_reg.hash_low,
                                   hash_high: req_reg.hash_high};
                    count_next = count_reg + COUNT_W'(1);
                    res_next   = '{write_load: 1'b1, outcome: OUT_ADDED,
                                   entry_index: OUT_IDX_W'(count_reg)};
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Hand the result to the response register once it is free.
                if (out_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        req_reg <= req_next;
        end_reg <= end_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

endmodule

// ----- sv/mrct_checker.sv -----
// ----------------------------------------------------------------------------
// mrct_checker
// Port-level checks for the memory range change tracker, bound to the top.
// ----------------------------------------------------------------------------
module mrct_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input mrct_pkg::mrct_req_t req,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input mrct_pkg::mrct_rsp_t rsp
);
    import mrct_pkg::*;

    // The load flag follows from the outcome code.
    a_load_matches_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.write_load
                       == (rsp.outcome != OUT_IGNORED && rsp.outcome != OUT_UNCHANGED)))
        else $error("write_load disagrees with outcome");

    // Ignored and table-full responses carry entry index zero.
    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.outcome == OUT_IGNORED || rsp.outcome == OUT_TABLE_FULL)
        |-> rsp.entry_index == '0)
        else $error("nonzero entry index on ignored or full response");

    // A request keeps the block busy for at least the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted on consecutive cycles");

    // A request that waits holds its payload.
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("waiting request changed or dropped");

    // A stalled response holds its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed or dropped");

endmodule

bind memory_range_change_tracker_unit mrct_checker u_mrct_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
